// ----- design/hngte_pkg.sv -----
// Shared types, constants and hash helpers for the hashed n-gram embedding block.
package hngte_pkg;

    localparam int MAX_DIMS_DEF   = 256;
    localparam int COUNT_BITS_DEF = 24;
    localparam int QUEUE_DEPTH    = 4;
    localparam int DIMS_W         = 9;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [15:0] Q_ONE     = 16'd32768;

    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_END  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] text_byte;
        logic [7:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  element_index;
        logic [15:0] element_value;
        logic [23:0] element_count;
        logic        index_out_of_range;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_BUMP,
        OP_END,
        OP_READ
    } op_kind_t;

    // one back-end operation; token selects the 3 half-unit increment
    typedef struct packed {
        op_kind_t    kind;
        logic [31:0] hash;
        logic        token;
        logic [7:0]  idx;
    } op_t;

    function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] c);
        logic [63:0] p;
        p = (h ^ {24'd0, c}) * FNV_PRIME;
        return p[31:0];
    endfunction

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage

// ----- design/hngte_queue.sv -----
// Small FIFO of operations between the front sequencer and the bucket engine.
module hngte_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_en,
    input  hngte_pkg::op_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output hngte_pkg::op_t rd_data,
    output logic           empty
);
    import hngte_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    op_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;

    assign full    = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (rd_en && !wr_en) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- design/hngte_front.sv -----
// Front sequencer: takes requests, folds bytes, hashes grams and tokens, issues operations.
module hngte_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hngte_pkg::in_item_t s_data,
    input  logic               back_busy,
    output logic               q_wr,
    output hngte_pkg::op_t     q_wdata,
    input  logic               q_full
);
    import hngte_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE, F_CLR, F_GRAM, F_TAIL, F_MIX, F_PUSH, F_TOK, F_ENDP, F_READP
    } fstate_t;

    fstate_t     state_reg;
    fstate_t     ret_reg;
    logic        is_end_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  idx_reg;
    logic [31:0] acc_reg;
    logic [23:0] bytes_reg;
    logic [1:0]  cnt_reg;
    logic [15:0] window_reg;
    logic [1:0]  fill_reg;
    logic [31:0] tok_reg;
    logic        in_tok_reg;
    logic        clr_pend_reg;
    logic        tok_push;

    assign s_ready  = (state_reg == F_IDLE) && !back_busy;
    assign tok_push = (is_end_reg || is_blank(byte_reg)) && in_tok_reg;

    always_comb begin
        q_wr    = 1'b0;
        q_wdata = '{kind: OP_CLEAR, hash: '0, token: 1'b0, idx: '0};
        unique case (state_reg)
            F_CLR: begin
                q_wr = clr_pend_reg && !q_full;
            end
            F_PUSH: begin
                q_wr         = !q_full;
                q_wdata.kind = OP_BUMP;
                q_wdata.hash = acc_reg;
            end
            F_TOK: begin
                q_wr          = tok_push && !q_full;
                q_wdata.kind  = OP_BUMP;
                q_wdata.hash  = tok_reg;
                q_wdata.token = 1'b1;
            end
            F_ENDP: begin
                q_wr         = !q_full;
                q_wdata.kind = OP_END;
            end
            F_READP: begin
                q_wr         = !q_full;
                q_wdata.kind = OP_READ;
                q_wdata.idx  = idx_reg;
            end
            default: begin
                q_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= F_IDLE;
            ret_reg      <= F_IDLE;
            cnt_reg      <= '0;
            window_reg   <= '0;
            fill_reg     <= '0;
            tok_reg      <= FNV_BASIS;
            in_tok_reg   <= 1'b0;
            clr_pend_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid && s_ready) begin
                        byte_reg <= fold_byte(s_data.text_byte);
                        idx_reg  <= s_data.read_index;
                        priority if (s_data.req_type == REQ_BYTE) begin
                            is_end_reg <= 1'b0;
                            if (s_data.text_byte != 8'd0) begin
                                state_reg <= F_CLR;
                            end
                        end else if (s_data.req_type == REQ_END) begin
                            is_end_reg <= 1'b1;
                            state_reg  <= F_CLR;
                        end else if (s_data.req_type == REQ_READ) begin
                            state_reg <= F_READP;
                        end else begin
                            state_reg <= F_IDLE;
                        end
                    end
                end
                F_CLR: begin
                    if (!clr_pend_reg) begin
                        state_reg <= F_GRAM;
                    end else if (!q_full) begin
                        clr_pend_reg <= 1'b0;
                        state_reg    <= F_GRAM;
                    end
                end
                F_GRAM: begin
                    if (fill_reg == 2'd2) begin
                        acc_reg   <= FNV_BASIS;
                        bytes_reg <= {byte_reg, window_reg[7:0], window_reg[15:8]};
                        cnt_reg   <= is_end_reg ? 2'd2 : 2'd3;
                        ret_reg   <= is_end_reg ? F_TAIL : F_TOK;
                        state_reg <= F_MIX;
                    end else begin
                        state_reg <= is_end_reg ? F_TAIL : F_TOK;
                    end
                end
                F_TAIL: begin
                    if (fill_reg != 2'd0) begin
                        acc_reg   <= FNV_BASIS;
                        bytes_reg <= {16'd0, window_reg[7:0]};
                        cnt_reg   <= 2'd1;
                        ret_reg   <= F_TOK;
                        state_reg <= F_MIX;
                    end else begin
                        state_reg <= F_TOK;
                    end
                end
                F_MIX: begin
                    acc_reg   <= fnv_mix(acc_reg, bytes_reg[7:0]);
                    bytes_reg <= {8'd0, bytes_reg[23:8]};
                    cnt_reg   <= cnt_reg - 2'd1;
                    if (cnt_reg == 2'd1) begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!q_full) begin
                        state_reg <= ret_reg;
                    end
                end
                F_TOK: begin
                    if (!tok_push || !q_full) begin
                        if (is_end_reg) begin
                            state_reg <= F_ENDP;
                        end else begin
                            if (is_blank(byte_reg)) begin
                                tok_reg    <= FNV_BASIS;
                                in_tok_reg <= 1'b0;
                            end else begin
                                tok_reg    <= fnv_mix(tok_reg, byte_reg);
                                in_tok_reg <= 1'b1;
                            end
                            window_reg <= {window_reg[7:0], byte_reg};
                            if (fill_reg != 2'd2) begin
                                fill_reg <= fill_reg + 2'd1;
                            end
                            state_reg <= F_IDLE;
                        end
                    end
                end
                F_ENDP: begin
                    if (!q_full) begin
                        window_reg   <= '0;
                        fill_reg     <= '0;
                        tok_reg      <= FNV_BASIS;
                        in_tok_reg   <= 1'b0;
                        clr_pend_reg <= 1'b1;
                        state_reg    <= F_IDLE;
                    end
                end
                F_READP: begin
                    if (!q_full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/hngte_back.sv -----
// Bucket engine: modulo, count updates, clearing, sum of squares and Q1.15 reads.
module hngte_back #(
    parameter int MAX_DIMS   = hngte_pkg::MAX_DIMS_DEF,
    parameter int COUNT_BITS = hngte_pkg::COUNT_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_empty,
    output logic                         q_rd,
    input  hngte_pkg::op_t               q_rdata,
    input  logic [hngte_pkg::DIMS_W-1:0] dims,
    output logic                         init_busy,
    output logic                         m_valid,
    input  logic                         m_ready,
    output hngte_pkg::out_item_t         m_data
);
    import hngte_pkg::*;

    localparam int ADDR_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CB     = COUNT_BITS;

    typedef enum logic [4:0] {
        B_INIT, B_IDLE, B_CLR, B_DIV, B_BRD, B_BWR, B_SRD, B_SMUL, B_SACC,
        B_RRD, B_RGOT, B_QCHK, B_QSQ, B_QP0, B_QP1, B_QCMP, B_RES
    } bstate_t;

    bstate_t           state_reg;
    logic [CB-1:0]     mem [MAX_DIMS];
    logic [CB-1:0]     rd_data_reg;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [CB-1:0]     mem_wdata;

    logic [ADDR_W-1:0] sweep_reg;
    logic [31:0]       div_q_reg;
    logic [DIMS_W-1:0] rem_reg;
    logic [4:0]        bit_reg;
    logic              token_reg;
    logic [DIMS_W-1:0] sum_i_reg;
    logic [63:0]       sq_reg;
    logic [63:0]       ss_acc_reg;
    logic [63:0]       ss_reg;
    logic              empty_reg;
    logic [7:0]        idx_reg;
    logic [63:0]       cc_reg;
    logic [15:0]       lo_reg;
    logic [15:0]       hi_reg;
    logic [15:0]       mid_reg;
    logic [31:0]       d2_reg;
    logic [95:0]       prod_reg;
    out_item_t         out_reg;
    logic              m_valid_reg;

    logic [DIMS_W:0]        div_t;
    logic [DIMS_W:0]        div_s;
    logic [CB:0]            bump_sum;
    logic [2*CB-1:0]        sq_w;
    logic [64:0]            acc_w;
    logic [16:0]            mid_w;
    logic [16:0]            d_w;
    logic [63:0]            hi_prod;
    logic [ADDR_W+DIMS_W-1:0] rem_ext;
    logic [ADDR_W+DIMS_W-1:0] sum_ext;
    logic [ADDR_W+7:0]      idx_ext;
    logic [CB+23:0]         cnt_ext;

    assign div_t    = {rem_reg, div_q_reg[31]};
    assign div_s    = div_t - {1'b0, dims};
    assign bump_sum = {1'b0, rd_data_reg} + (CB+1)'(token_reg ? 2'd3 : 2'd2);
    assign sq_w     = rd_data_reg * rd_data_reg;
    assign acc_w    = {1'b0, ss_acc_reg} + {1'b0, sq_reg};
    assign mid_w    = ({1'b0, lo_reg} + {1'b0, hi_reg} + 17'd1) >> 1;
    assign d_w      = {mid_reg, 1'b0} - 17'd1;
    assign hi_prod  = d2_reg * ss_reg[63:32];
    assign rem_ext  = {{ADDR_W{1'b0}}, rem_reg};
    assign sum_ext  = {{ADDR_W{1'b0}}, sum_i_reg};
    assign idx_ext  = {{ADDR_W{1'b0}}, idx_reg};
    assign cnt_ext  = {24'd0, rd_data_reg};

    assign q_rd      = (state_reg == B_IDLE) && !q_empty;
    assign init_busy = (state_reg == B_INIT);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        mem_addr  = '0;
        mem_we    = 1'b0;
        mem_wdata = '0;
        unique case (state_reg)
            B_INIT, B_CLR: begin
                mem_addr = sweep_reg;
                mem_we   = 1'b1;
            end
            B_BRD: begin
                mem_addr = rem_ext[ADDR_W-1:0];
            end
            B_BWR: begin
                mem_addr  = rem_ext[ADDR_W-1:0];
                mem_we    = 1'b1;
                mem_wdata = bump_sum[CB] ? {CB{1'b1}} : bump_sum[CB-1:0];
            end
            B_SRD: begin
                mem_addr = sum_ext[ADDR_W-1:0];
            end
            B_RRD: begin
                mem_addr = idx_ext[ADDR_W-1:0];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_INIT;
            sweep_reg   <= '0;
            ss_reg      <= '0;
            empty_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                B_INIT, B_CLR: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == ADDR_W'(MAX_DIMS - 1)) begin
                        sweep_reg <= '0;
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!q_empty) begin
                        unique case (q_rdata.kind)
                            OP_CLEAR: begin
                                state_reg <= B_CLR;
                            end
                            OP_BUMP: begin
                                div_q_reg <= q_rdata.hash;
                                token_reg <= q_rdata.token;
                                rem_reg   <= '0;
                                bit_reg   <= 5'd31;
                                state_reg <= B_DIV;
                            end
                            OP_END: begin
                                sum_i_reg  <= '0;
                                ss_acc_reg <= '0;
                                state_reg  <= B_SRD;
                            end
                            OP_READ: begin
                                idx_reg               <= q_rdata.idx;
                                out_reg.element_index <= q_rdata.idx;
                                if ({1'b0, q_rdata.idx} >= dims) begin
                                    out_reg.element_value      <= '0;
                                    out_reg.element_count      <= '0;
                                    out_reg.index_out_of_range <= 1'b1;
                                    m_valid_reg                <= 1'b1;
                                    state_reg                  <= B_RES;
                                end else begin
                                    out_reg.index_out_of_range <= 1'b0;
                                    state_reg                  <= B_RRD;
                                end
                            end
                            default: begin
                                state_reg <= B_IDLE;
                            end
                        endcase
                    end
                end
                B_DIV: begin
                    rem_reg   <= div_s[DIMS_W] ? div_t[DIMS_W-1:0] : div_s[DIMS_W-1:0];
                    div_q_reg <= {div_q_reg[30:0], 1'b0};
                    bit_reg   <= bit_reg - 5'd1;
                    if (bit_reg == 5'd0) begin
                        state_reg <= B_BRD;
                    end
                end
                B_BRD: begin
                    state_reg <= B_BWR;
                end
                B_BWR: begin
                    state_reg <= B_IDLE;
                end
                B_SRD: begin
                    state_reg <= B_SMUL;
                end
                B_SMUL: begin
                    sq_reg    <= 64'(sq_w);
                    state_reg <= B_SACC;
                end
                B_SACC: begin
                    if (sum_i_reg == dims - 1'b1) begin
                        ss_reg    <= acc_w[64] ? {64{1'b1}} : acc_w[63:0];
                        empty_reg <= !acc_w[64] && (acc_w[63:0] == 64'd0);
                        state_reg <= B_IDLE;
                    end else begin
                        ss_acc_reg <= acc_w[64] ? {64{1'b1}} : acc_w[63:0];
                        sum_i_reg  <= sum_i_reg + 1'b1;
                        state_reg  <= B_SRD;
                    end
                end
                B_RRD: begin
                    state_reg <= B_RGOT;
                end
                B_RGOT: begin
                    out_reg.element_count <= cnt_ext[23:0];
                    if (empty_reg) begin
                        out_reg.element_value <= (idx_reg == 8'd0) ? Q_ONE : 16'd0;
                        m_valid_reg           <= 1'b1;
                        state_reg             <= B_RES;
                    end else begin
                        cc_reg    <= 64'(sq_w);
                        lo_reg    <= '0;
                        hi_reg    <= Q_ONE;
                        state_reg <= B_QCHK;
                    end
                end
                B_QCHK: begin
                    if (lo_reg < hi_reg) begin
                        mid_reg   <= mid_w[15:0];
                        state_reg <= B_QSQ;
                    end else begin
                        out_reg.element_value <= lo_reg;
                        m_valid_reg           <= 1'b1;
                        state_reg             <= B_RES;
                    end
                end
                B_QSQ: begin
                    d2_reg    <= d_w[15:0] * d_w[15:0];
                    state_reg <= B_QP0;
                end
                B_QP0: begin
                    prod_reg  <= 96'(d2_reg * ss_reg[31:0]);
                    state_reg <= B_QP1;
                end
                B_QP1: begin
                    prod_reg  <= prod_reg + {hi_prod, 32'd0};
                    state_reg <= B_QCMP;
                end
                B_QCMP: begin
                    if (prod_reg <= {cc_reg, 32'd0}) begin
                        lo_reg <= mid_reg;
                    end else begin
                        hi_reg <= mid_reg - 16'd1;
                    end
                    state_reg <= B_QCHK;
                end
                B_RES: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_bucket_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_BWR |-> rem_reg < dims)
        else $error("bucket index not below dims");
    a_value_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.element_value <= Q_ONE)
        else $error("normalized value above 1.0");
    a_search_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_QCHK |-> lo_reg <= hi_reg)
        else $error("search bounds crossed");
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.index_out_of_range |->
            m_data.element_value == 16'd0 && m_data.element_count == 24'd0)
        else $error("out of range read carries data");
`endif

endmodule

// ----- design/hashed_ngram_text_embedding.sv -----
// Top level of the hashed n-gram text embedding block.
// Text bytes hash folded trigrams and whitespace tokens (FNV-1a) into dims_in_use
// buckets, and an end request adds the closing bigram and unigram; it then latches
// the sum of squared counts, and read requests return one count normalized to
// unsigned Q1.15. A front sequencer takes one request at a time and hashes each
// byte (one FNV multiply per cycle), feeding a 4-entry operation queue. The bucket
// engine behind it runs a 32-step bit-serial modulo and a single-port
// read-modify-write per bucket increment; an end request sweeps the buckets in
// use, reading, squaring and accumulating each; the first byte or end of a new
// text clears MAX_DIMS entries, one per cycle; a read runs a search loop of at
// most 16 steps. After reset the bucket memory is cleared before the first
// request is taken; configuration writes are taken at any time.
module hashed_ngram_text_embedding #(
    parameter int MAX_DIMS   = hngte_pkg::MAX_DIMS_DEF,
    parameter int COUNT_BITS = hngte_pkg::COUNT_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  hngte_pkg::in_item_t          s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output hngte_pkg::out_item_t         m_data,
    input  logic                         cfg_wr_en,
    input  logic [hngte_pkg::DIMS_W-1:0] cfg_wr_data
);
    import hngte_pkg::*;

    localparam int DIMS_RESET = (MAX_DIMS < 256) ? MAX_DIMS : 256;

    logic [DIMS_W-1:0] dims_reg;
    logic              q_wr;
    logic              q_rd;
    logic              q_full;
    logic              q_empty;
    op_t               q_wdata;
    op_t               q_rdata;
    logic              back_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg <= DIMS_W'(DIMS_RESET);
        end else if (cfg_wr_en) begin
            priority if (cfg_wr_data == '0) begin
                dims_reg <= DIMS_W'(1);
            end else if ({4'd0, cfg_wr_data} > 13'(MAX_DIMS)) begin
                dims_reg <= DIMS_W'(MAX_DIMS);
            end else begin
                dims_reg <= cfg_wr_data;
            end
        end
    end

    hngte_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .back_busy (back_busy),
        .q_wr      (q_wr),
        .q_wdata   (q_wdata),
        .q_full    (q_full)
    );

    hngte_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    hngte_back #(
        .MAX_DIMS   (MAX_DIMS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .q_rdata   (q_rdata),
        .dims      (dims_reg),
        .init_busy (back_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
